@@ rtl/assert_macros.svh @@
// Assertion macros shared by the window distinct count RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Overlapping implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/wdc_pkg.sv @@
// Package for the window distinct count block: sizes, function codes and the
// request, command, result, queue head and status structs. Depends on nothing.
`timescale 1ns / 1ps

package wdc_pkg;

    // Sequence and colour table sizes.
    localparam int SEQ_DEPTH   = 4096;
    localparam int COLOR_COUNT = 2048;

    // Field widths of the request and result.
    localparam int LOAD_POS_W    = 12;
    localparam int COLOR_CODE_W  = 11;
    localparam int RANGE_START_W = 12;
    localparam int RANGE_END_W   = 13;
    localparam int QUERY_TAG_W   = 12;
    localparam int ANSWER_TAG_W  = 12;
    localparam int DISTINCT_W    = 12;

    // Derived internal widths.
    localparam int SEQ_AW   = $clog2(SEQ_DEPTH);
    localparam int WIN_W    = $clog2(SEQ_DEPTH + 1);
    localparam int CMP_W    = WIN_W + 1;
    localparam int COLOR_W  = $clog2(COLOR_COUNT);
    localparam int COUNT_W  = 14;
    localparam int TOTAL_W  = $clog2(COLOR_COUNT + 1);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [LOAD_POS_W-1:0]    load_position;
        logic [COLOR_CODE_W-1:0]  color_code;
        logic [RANGE_START_W-1:0] range_start;
        logic [RANGE_END_W-1:0]   range_end;
        logic [QUERY_TAG_W-1:0]   query_tag;
    } t_req;

    typedef struct packed {
        logic [ANSWER_TAG_W-1:0] answer_tag;
        logic [DISTINCT_W-1:0]   distinct_total;
    } t_result;

    // Classified request as held in the queue; window bounds already saturated.
    typedef struct packed {
        logic                   func;
        logic [SEQ_AW-1:0]      seq_addr;
        logic [COLOR_W-1:0]     color;
        logic [WIN_W-1:0]       lo;
        logic [WIN_W-1:0]       hi;
        logic [QUERY_TAG_W-1:0] tag;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_status;

endpackage

@@ rtl/window_distinct_count.sv @@
// Top level of the window distinct count block: range distinct-value queries
// over a loaded colour sequence. Depends on wdc_pkg, wdc_front and wdc_back.
`timescale 1ns / 1ps

// How to use this block.
// A request is presented on i_req with start high and is taken at a rising
// edge where busy is low. A load request (func zero) writes one colour code
// into the sequence memory and returns nothing. A query request (func one)
// moves the kept window to the half-open range [range_start, range_end),
// both ends saturated to the sequence depth, and returns one result: the
// query tag and the number of distinct colours in the window.
// Each result on o_result is marked by o_strobe, high for exactly one cycle;
// the receiver must take it then, as it cannot hold results off.
// Requests pass through a two-entry queue, and busy is high while that queue
// is full. Results leave in request order.
// A load is written into the sequence memory when the back end takes it from the
// queue, so it waits while an earlier query is still walking. A query moves
// its window one position at a time; each move passes through the registered
// sequence memory read, the registered count memory read and the count
// write-back, and the strobe follows once both window ends are in place.
// Reset is synchronous and active low. After reset the colour count memory is
// cleared one entry a cycle, all of its entries in turn, with busy held high.
// The sequence memory is not cleared; only loaded positions may be queried.

module window_distinct_count
    import wdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_back_status back_status;
    t_queue_head  queue_head;

    // Front: accepts requests, saturates the range and queues commands.
    wdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .i_back  (back_status),
        .o_head  (queue_head)
    );

    // Back: performs loads and walks the window for queries.
    wdc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (queue_head),
        .o_status (back_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ rtl/wdc_front.sv @@
// Front end of the window distinct count block: request intake, bound
// saturation and the short command queue. Depends on wdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdc_front
    import wdc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_req         i_req,
    output logic         o_busy,
    input  t_back_status i_back,
    output t_queue_head  o_head
);

    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    t_cmd              r_queue [QUEUE_DEPTH];

    logic accept;
    logic load_ok;
    logic push;
    logic full;
    t_cmd cmd;

    assign full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_busy = full || i_back.clearing;
    assign accept = i_start && !o_busy;

    // A load beyond the sequence is dropped after it is accepted.
    assign load_ok = (CMP_W'(i_req.load_position) < CMP_W'(SEQ_DEPTH));
    assign push    = accept && ((i_req.func == FUNC_QUERY) || load_ok);

    always_comb begin
        cmd.func     = i_req.func;
        cmd.seq_addr = SEQ_AW'(i_req.load_position);
        cmd.color    = COLOR_W'(i_req.color_code);
        cmd.tag      = i_req.query_tag;
        if (CMP_W'(i_req.range_start) > CMP_W'(SEQ_DEPTH)) begin
            cmd.lo = WIN_W'(SEQ_DEPTH);
        end else begin
            cmd.lo = WIN_W'(i_req.range_start);
        end
        if (CMP_W'(i_req.range_end) > CMP_W'(SEQ_DEPTH)) begin
            cmd.hi = WIN_W'(SEQ_DEPTH);
        end else begin
            cmd.hi = WIN_W'(i_req.range_end);
        end
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_back.pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        unique case ({push, i_back.pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

    `ASSERT_IMPLY(a_pop_nonempty, i_back.pop, r_count != '0, "pop from an empty queue")
    `ASSERT_IMPLY(a_push_room, push, !full, "push into a full queue")
    `ASSERT_CLK(a_count_bound, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

@@ rtl/wdc_back.sv @@
// Back end of the window distinct count block: sequence memory, colour count
// memory and the window walker. Depends on wdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdc_back
    import wdc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_queue_head  i_head,
    output t_back_status o_status,
    output logic         o_strobe,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_SEQ,
        S_CNT
    } t_state;

    t_state              r_state;
    logic [COLOR_W-1:0]  r_clr_addr;
    logic [WIN_W-1:0]    r_left;
    logic [WIN_W-1:0]    r_right;
    logic [TOTAL_W-1:0]  r_total;
    t_cmd                r_cmd;
    logic                r_add;
    logic [COLOR_W-1:0]  r_color;
    logic                r_out_valid;
    t_result             r_out;

    logic [COLOR_W-1:0]        r_seq_mem [SEQ_DEPTH];
    logic signed [COUNT_W-1:0] r_cnt_mem [COLOR_COUNT];
    logic [COLOR_W-1:0]        r_seq_q;
    logic signed [COUNT_W-1:0] r_cnt_q;

    logic                      pop;
    logic                      seq_we;
    logic                      walk_move;
    logic                      walk_add;
    logic [WIN_W-1:0]          walk_win;
    logic [SEQ_AW-1:0]         walk_pos;
    logic [WIN_W-1:0]          n_left;
    logic [WIN_W-1:0]          n_right;
    logic signed [COUNT_W-1:0] cnt_new;
    logic                      cnt_we;
    logic [COLOR_W-1:0]        cnt_waddr;
    logic signed [COUNT_W-1:0] cnt_wdata;

    assign pop    = (r_state == S_IDLE) && i_head.valid;
    assign seq_we = pop && (i_head.cmd.func == FUNC_LOAD);

    assign o_status.pop      = pop;
    assign o_status.clearing = (r_state == S_CLEAR);

    // Next window step, in the fixed order grow right, shrink right,
    // shrink left, grow left.
    always_comb begin
        walk_move = 1'b1;
        walk_add  = 1'b1;
        walk_win  = r_right;
        n_left    = r_left;
        n_right   = r_right;
        priority if (r_right < r_cmd.hi) begin
            walk_win = r_right;
            n_right  = r_right + WIN_W'(1);
        end else if (r_right > r_cmd.hi) begin
            walk_add = 1'b0;
            walk_win = r_right - WIN_W'(1);
            n_right  = r_right - WIN_W'(1);
        end else if (r_left < r_cmd.lo) begin
            walk_add = 1'b0;
            walk_win = r_left;
            n_left   = r_left + WIN_W'(1);
        end else if (r_left > r_cmd.lo) begin
            walk_win = r_left - WIN_W'(1);
            n_left   = r_left - WIN_W'(1);
        end else begin
            walk_move = 1'b0;
        end
    end

    assign walk_pos = walk_win[SEQ_AW-1:0];

    assign cnt_new   = r_add ? r_cnt_q + COUNT_W'(1) : r_cnt_q - COUNT_W'(1);
    assign cnt_we    = (r_state == S_CLEAR) || (r_state == S_CNT);
    assign cnt_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_color;
    assign cnt_wdata = (r_state == S_CLEAR) ? '0 : cnt_new;

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq_mem[i_head.cmd.seq_addr] <= i_head.cmd.color;
        end
        if ((r_state == S_WALK) && walk_move) begin
            r_seq_q <= r_seq_mem[walk_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (r_state == S_SEQ) begin
            r_cnt_q <= r_cnt_mem[r_seq_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + COLOR_W'(1);
                    if (r_clr_addr == COLOR_W'(COLOR_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop && (i_head.cmd.func == FUNC_QUERY)) begin
                        r_cmd   <= i_head.cmd;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_move) begin
                        r_add   <= walk_add;
                        r_left  <= n_left;
                        r_right <= n_right;
                        r_state <= S_SEQ;
                    end else begin
                        r_out_valid          <= 1'b1;
                        r_out.answer_tag     <= r_cmd.tag;
                        r_out.distinct_total <= DISTINCT_W'(r_total);
                        r_state              <= S_IDLE;
                    end
                end
                S_SEQ: begin
                    r_color <= r_seq_q;
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (r_add && (cnt_new == COUNT_W'(1))) begin
                        r_total <= r_total + TOTAL_W'(1);
                    end else if (!r_add && (cnt_new == '0)) begin
                        r_total <= r_total - TOTAL_W'(1);
                    end
                    r_state <= S_WALK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    `ASSERT_IMPLY(a_out_window, r_out_valid,
        (r_left == r_cmd.lo) && (r_right == r_cmd.hi), "answer before the window arrived")
    `ASSERT_IMPLY(a_out_idle, r_out_valid, r_state == S_IDLE, "answer outside idle")
    `ASSERT_CLK(a_right_bound, r_right <= WIN_W'(SEQ_DEPTH), "window right end past sequence")
    `ASSERT_CLK(a_total_bound, r_total <= TOTAL_W'(COLOR_COUNT), "distinct total past colours")

endmodule
